### rtl/elevator_scan_controller_macros.svh
// Assertion macros used by the checker module of the elevator scan controller.
`ifndef ELEVATOR_SCAN_CONTROLLER_MACROS_SVH
`define ELEVATOR_SCAN_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and disabled in reset.
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock and disabled in reset.
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/esc_pkg.sv
// Package with the codes, field widths and beat layout of the elevator scan controller.
`timescale 1ns / 1ps

package esc_pkg;

   // Floors in the building. The floor, request and pending widths below are sized for it.
   localparam int MAX_FLOORS = 16;

   localparam int FLOOR_W = 4;
   localparam int TIMER_W = 8;
   localparam int FIU_W = 5;
   localparam int PENDING_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_TDATA_W = 8;

   // Result beat layout, lowest bit first.
   localparam int RSP_CAR_LSB = 0;
   localparam int RSP_DIR_LSB = RSP_CAR_LSB + FLOOR_W;
   localparam int RSP_DOOR_LSB = RSP_DIR_LSB + 2;
   localparam int RSP_COUNT_LSB = RSP_DOOR_LSB + 1;
   localparam int RSP_TARGET_LSB = RSP_COUNT_LSB + TIMER_W;
   localparam int RSP_PEND_LSB = RSP_TARGET_LSB + FLOOR_W;
   localparam int RSP_USED_W = RSP_PEND_LSB + PENDING_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;

   typedef logic signed [1:0] heading_type;

   localparam heading_type HEAD_UP = 2'sb01;
   localparam heading_type HEAD_DOWN = 2'sb11;
   localparam heading_type HEAD_STOP = 2'sb00;

   localparam logic [CSR_INDEX_W-1:0] CSR_FLOORS_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOOR_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_FLOOR = 2'd2;

   localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;
   localparam logic [TIMER_W-1:0] DOOR_TICKS_RESET = 8'd9;
   localparam logic [TIMER_W-1:0] TIMER_MAX = 8'd255;

   localparam logic REQ_FUNC_TICK = 1'b0;
   localparam logic REQ_FUNC_PRESS = 1'b1;

endpackage

### rtl/elevator_scan_controller.sv
// Top level of the elevator scan controller: request bookkeeping, door timer and scan logic.
`timescale 1ns / 1ps

// Elevator car controller with a scan policy. Each input beat is either a floor button
// press (req_tuser high), which records a request for a served floor, or a time tick
// (req_tuser low), which advances the door timer, opens the door on arrival, or picks a
// target by scanning the outstanding requests and moves the car one floor. Every input
// beat yields exactly one result beat with the state after that beat. The block takes a
// new beat in every cycle unless the result side stalls: all of the work is one pass of
// combinational logic from the state registers to the result register, so a result
// appears in the cycle after its input beat and the rate is one beat per clock. The result
// register decouples the two sides: req_tready stays high while the result register is
// empty or being drained in the same cycle. Configuration writes on the csr_ channel are
// always accepted; write them only while the block is idle. Writing the start floor moves
// the car only when the door is closed and no request is outstanding.
module elevator_scan_controller
   import esc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [3:0] button_floor, [7:4] zero
   input  logic                   req_tuser,  // [0] func: 0 time tick, 1 button press
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [3:0] car_floor, [5:4] direction, [6] door_open, [14:7] door_count,
   // [18:15] target_floor, [34:19] pending, [39:35] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int LIM_W = $clog2(MAX_FLOORS + 1);
   localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(MAX_FLOORS - 1);

   // Configuration registers.
   logic [FIU_W-1:0]      fiu_ff, fiu_in;
   logic [TIMER_W-1:0]    door_ticks_ff, door_ticks_in;

   // Car state.
   logic [FLOOR_W-1:0]    position_ff, position_in;
   heading_type           heading_ff, heading_in;
   logic [FLOOR_W-1:0]    dest_ff, dest_in;
   logic [MAX_FLOORS-1:0] requests_ff, requests_in;
   logic                  door_open_ff, door_open_in;
   logic [TIMER_W-1:0]    door_timer_ff, door_timer_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  csr_accept;
   logic [FLOOR_W-1:0]    button_floor;
   logic [LIM_W-1:0]      limit;
   logic [MAX_FLOORS-1:0] served_mask;
   logic [MAX_FLOORS-1:0] live;
   logic [MAX_FLOORS-1:0] live_next;
   logic [MAX_FLOORS-1:0] pos_hot;
   logic [MAX_FLOORS-1:0] btn_hot;
   logic [MAX_FLOORS-1:0] up_cand;
   logic [MAX_FLOORS-1:0] dn_cand;
   logic                  up_hit, dn_hit, any_hit;
   logic [FLOOR_W-1:0]    up_idx, dn_idx, any_idx;
   logic                  scan_hit;
   logic [FLOOR_W-1:0]    scan_idx;
   logic [FLOOR_W-1:0]    target;
   logic [TIMER_W-1:0]    timer_inc;
   logic [PENDING_W-1:0]  pending;
   logic [FLOOR_W-1:0]    start_pos;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign csr_accept = csr_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign button_floor = req_tdata[FLOOR_W-1:0];

   // A floor count of zero serves one floor; counts above the building are clamped.
   always_comb begin
      if (fiu_ff == '0) begin
         limit = LIM_W'(1);
      end else if (32'(fiu_ff) > MAX_FLOORS) begin
         limit = LIM_W'(MAX_FLOORS);
      end else begin
         limit = LIM_W'(fiu_ff);
      end
   end

   // Per-floor decodes: served floors, the car's floor and the pressed floor.
   always_comb begin
      for (int i = 0; i < MAX_FLOORS; i++) begin
         served_mask[i] = 32'(limit) > i;
         pos_hot[i] = 32'(position_ff) == i;
         btn_hot[i] = (32'(button_floor) == i) && served_mask[i];
         up_cand[i] = 32'(position_ff) <= i;
         dn_cand[i] = 32'(position_ff) >= i;
      end
      live = requests_ff & served_mask;
      up_cand = up_cand & live;
      dn_cand = dn_cand & live;
   end

   // Priority encoders for the three scan orders. The lowest hit wins going up or
   // from a standstill, the highest hit at or below the car wins going down.
   always_comb begin
      up_hit = 1'b0;
      up_idx = '0;
      any_hit = 1'b0;
      any_idx = '0;
      for (int i = MAX_FLOORS - 1; i >= 0; i--) begin
         if (up_cand[i]) begin
            up_hit = 1'b1;
            up_idx = FLOOR_W'(i);
         end
         if (live[i]) begin
            any_hit = 1'b1;
            any_idx = FLOOR_W'(i);
         end
      end
      dn_hit = 1'b0;
      dn_idx = '0;
      for (int i = 0; i < MAX_FLOORS; i++) begin
         if (dn_cand[i]) begin
            dn_hit = 1'b1;
            dn_idx = FLOOR_W'(i);
         end
      end
   end

   always_comb begin
      unique case (heading_ff)
         HEAD_UP: begin
            scan_hit = up_hit;
            scan_idx = up_idx;
         end
         HEAD_DOWN: begin
            scan_hit = dn_hit;
            scan_idx = dn_idx;
         end
         default: begin
            scan_hit = any_hit;
            scan_idx = any_idx;
         end
      endcase
   end

   assign timer_inc = (door_timer_ff == TIMER_MAX) ? door_timer_ff : door_timer_ff + 1'b1;
   assign target = scan_hit ? scan_idx : position_ff;
   assign start_pos = (32'(csr_data[FLOOR_W-1:0]) >= MAX_FLOORS) ? TOP_FLOOR
                                                                : csr_data[FLOOR_W-1:0];

   // Next state for one beat, followed by configuration writes.
   always_comb begin
      fiu_in = fiu_ff;
      door_ticks_in = door_ticks_ff;
      position_in = position_ff;
      heading_in = heading_ff;
      dest_in = dest_ff;
      requests_in = requests_ff;
      door_open_in = door_open_ff;
      door_timer_in = door_timer_ff;

      if (req_accept) begin
         if (req_tuser == REQ_FUNC_PRESS) begin
            requests_in = requests_ff | btn_hot;
         end else if (door_open_ff) begin
            // Door open: count ticks, and on closing retire the request here.
            door_timer_in = timer_inc;
            if (timer_inc >= door_ticks_ff) begin
               door_open_in = 1'b0;
               requests_in = requests_ff & ~pos_hot;
            end
         end else if (live == '0) begin
            heading_in = HEAD_STOP;
         end else if (|(live & pos_hot) && (position_ff == dest_ff || heading_ff == HEAD_STOP))
         begin
            // Arrival at the target, or a request at the floor of a stopped car.
            dest_in = position_ff;
            door_open_in = 1'b1;
            door_timer_in = '0;
         end else begin
            dest_in = target;
            if (!scan_hit) begin
               heading_in = HEAD_STOP;
            end
            if (position_ff < target) begin
               heading_in = HEAD_UP;
               position_in = position_ff + 1'b1;
            end else if (position_ff > target) begin
               heading_in = HEAD_DOWN;
               position_in = position_ff - 1'b1;
            end
         end
      end

      if (csr_accept) begin
         unique case (csr_index)
            CSR_FLOORS_IN_USE: fiu_in = csr_data[FIU_W-1:0];
            CSR_DOOR_TICKS:    door_ticks_in = csr_data[TIMER_W-1:0];
            CSR_START_FLOOR: begin
               // The car is only placed while it stands idle.
               if (!door_open_ff && live == '0) begin
                  position_in = start_pos;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Pending requests reported in the result, limited to the served floors.
   always_comb begin
      live_next = requests_in & served_mask;
      pending = '0;
      for (int i = 0; i < PENDING_W; i++) begin
         if (i < MAX_FLOORS) begin
            pending[i] = live_next[i];
         end
      end
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_CAR_LSB +: FLOOR_W] = position_in;
      rsp_data_in[RSP_DIR_LSB +: 2] = heading_in;
      rsp_data_in[RSP_DOOR_LSB] = door_open_in;
      rsp_data_in[RSP_COUNT_LSB +: TIMER_W] = door_timer_in;
      rsp_data_in[RSP_TARGET_LSB +: FLOOR_W] = dest_in;
      rsp_data_in[RSP_PEND_LSB +: PENDING_W] = pending;
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= FIU_RESET;
         door_ticks_ff <= DOOR_TICKS_RESET;
         position_ff <= '0;
         heading_ff <= HEAD_UP;
         dest_ff <= '0;
         requests_ff <= '0;
         door_open_ff <= 1'b0;
         door_timer_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fiu_ff <= fiu_in;
         door_ticks_ff <= door_ticks_in;
         position_ff <= position_in;
         heading_ff <= heading_in;
         dest_ff <= dest_in;
         requests_ff <= requests_in;
         door_open_ff <= door_open_in;
         door_timer_ff <= door_timer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### rtl/esc_checker.sv
// Port-level checker for the elevator scan controller and its bind statement.
`timescale 1ns / 1ps
`include "elevator_scan_controller_macros.svh"

module esc_checker
   import esc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A waiting result beat must hold its contents.
   `ESC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result beat changed while stalled")

   // With the result register empty the block must take a request beat.
   `ESC_ASSERT_NOW(a_ready_when_empty, !rsp_tvalid, req_tready, "request side stalled with empty result register")

   // The door only stands open at the floor that was the target.
   `ESC_ASSERT_NOW(a_door_at_target, rsp_tvalid && rsp_tdata[RSP_DOOR_LSB], rsp_tdata[RSP_TARGET_LSB +: FLOOR_W] == rsp_tdata[RSP_CAR_LSB +: FLOOR_W], "door open away from target floor")

   // Direction is up, down or stopped, never the unused code.
   `ESC_ASSERT_NOW(a_dir_code, rsp_tvalid, rsp_tdata[RSP_DIR_LSB +: 2] != 2'b10, "invalid direction code")

endmodule

bind elevator_scan_controller esc_checker u_esc_checker (.*);
